// ===== sv/piecewise_linear_color_lookup_defines.svh =====
// assertion macros for the piecewise linear color lookup
// depends on nothing; the including module provides clk and rst_n
`ifndef PIECEWISE_LINEAR_COLOR_LOOKUP_DEFINES_SVH
`define PIECEWISE_LINEAR_COLOR_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PLC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plc assertion failed");
// next-cycle implication
`define PLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plc assertion failed");
`else
`define PLC_ASSERT_NOW(lbl, ante, cons)
`define PLC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/plc_pkg.sv =====
// shared types and constants for the piecewise linear color lookup
// no dependencies
package plc_pkg;

  localparam int PLC_POINTS = 16;
  localparam int KEY_W      = 16;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int COLOR_W    = CH_W * NUM_CH;
  localparam int STATUS_W   = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic            command;
    logic [KEY_W-1:0] key;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } plc_in_t;

  typedef struct packed {
    logic [CH_W-1:0]     out_red;
    logic [CH_W-1:0]     out_green;
    logic [CH_W-1:0]     out_blue;
    logic [CH_W-1:0]     out_alpha;
    logic [STATUS_W-1:0] status;
  } plc_out_t;

endpackage

// ===== sv/plc_ram.sv =====
// generic single write port, single read port ram with registered read
// depends on nothing
module plc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/piecewise_linear_color_lookup.sv =====
// piecewise linear color lookup: sorted control point table with interpolation
// depends on plc_pkg, plc_ram and piecewise_linear_color_lookup_defines.svh
//
// usage
// - input channel in_valid/in_ready/in_data carries one command per transfer:
//   insert (or replace) a control point, or look up a sample key
// - result channel out_valid/out_ready/out_data returns one result per command:
//   four interpolated channel codes and a status (ok, table full, table empty)
// - one item at a time: in_ready is high only while the sequencer is idle
// - keys and colors live in two rams with a registered read; every table
//   read takes an address state, then a compare or copy state
// - insert: each entry scanned passes S_SCAN and S_CMP, each entry moved up
//   passes S_SHIFT and S_SHWR, then a new point is written in S_SHIFT
// - lookup: each entry scanned passes S_SCAN and S_CMP, then either S_EDGE
//   takes a colour as is, or the interpolation runs: per channel one
//   shared 8x16 multiplier runs twice and an 8-step restoring divider
//   produces the truncated quotient
// - a finished result sits in an output register; while the receiver stalls
//   the next result waits in the finish state and no new item is taken
// - reset (rst_n low, synchronous) empties the table and drops any result;
//   ram contents are not cleared since only entries below the count are read

`include "piecewise_linear_color_lookup_defines.svh"

module piecewise_linear_color_lookup
  import plc_pkg::*;
#(
  parameter int POINTS = PLC_POINTS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  plc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output plc_out_t out_data
);

  localparam int IW    = $clog2(POINTS);
  localparam int CW    = $clog2(POINTS + 1);
  localparam int NUM_W = KEY_W + CH_W;
  localparam int DIV_W = KEY_W + CH_W - 1;
  localparam int BIT_W = $clog2(CH_W);
  localparam int CHS_W = $clog2(NUM_CH);

  // one-hot sequencer states
  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_SCAN  = 12'b0000_0000_0010,
    S_CMP   = 12'b0000_0000_0100,
    S_SHIFT = 12'b0000_0000_1000,
    S_SHWR  = 12'b0000_0001_0000,
    S_EDGE  = 12'b0000_0010_0000,
    S_GETHI = 12'b0000_0100_0000,
    S_GETLO = 12'b0000_1000_0000,
    S_MUL0  = 12'b0001_0000_0000,
    S_MUL1  = 12'b0010_0000_0000,
    S_DIV   = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } plc_state_t;

  plc_state_t state_r, state_nxt;

  // latched command
  logic               cmd_r, cmd_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;

  // table bookkeeping
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] j_r, j_nxt;

  // interpolation operands
  logic [KEY_W-1:0]   k1_r, k1_nxt;
  logic [KEY_W-1:0]   d_r, d_nxt;
  logic [KEY_W-1:0]   t_r, t_nxt;
  logic [KEY_W-1:0]   w_r, w_nxt;
  logic [COLOR_W-1:0] c0_r, c0_nxt;
  logic [COLOR_W-1:0] c1_r, c1_nxt;
  logic [CHS_W-1:0]   ch_r, ch_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [DIV_W-1:0]   div_r, div_nxt;
  logic [CH_W-1:0]    q_r, q_nxt;

  // result being built and output register
  logic [COLOR_W-1:0]  res_color_r, res_color_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  plc_out_t            out_data_r, out_data_nxt;

  // ram ports
  logic               ram_we;
  logic [IW-1:0]      ram_wr_addr;
  logic [IW-1:0]      ram_rd_addr;
  logic [KEY_W-1:0]   ram_wr_key;
  logic [COLOR_W-1:0] ram_wr_color;
  logic [KEY_W-1:0]   rd_key;
  logic [COLOR_W-1:0] rd_color;

  // shared arithmetic
  logic [CH_W-1:0]  c0_ch, c1_ch, mul_a;
  logic [KEY_W-1:0] mul_b;
  logic [NUM_W-1:0] prod;
  logic             div_ge;
  logic [CW-1:0]    cnt_m1, idx_m1, j_m1;
  logic             in_xfer, out_free, full;

  plc_ram #(.WIDTH(KEY_W), .DEPTH(POINTS)) u_key_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_key),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_key)
  );

  plc_ram #(.WIDTH(COLOR_W), .DEPTH(POINTS)) u_color_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_color),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_color)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cnt_m1 = count_r - 1'b1;
  assign idx_m1 = idx_r - 1'b1;
  assign j_m1   = j_r - 1'b1;
  assign full   = (count_r == CW'(POINTS));

  // channel select and the one shared multiplier
  assign c0_ch  = c0_r[CH_W*ch_r +: CH_W];
  assign c1_ch  = c1_r[CH_W*ch_r +: CH_W];
  assign mul_a  = (state_r == S_MUL0) ? c0_ch : c1_ch;
  assign mul_b  = (state_r == S_MUL0) ? w_r : t_r;
  assign prod   = {{KEY_W{1'b0}}, mul_a} * {{CH_W{1'b0}}, mul_b};
  assign div_ge = (num_r >= {1'b0, div_r});

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    color_nxt      = color_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    j_nxt          = j_r;
    k1_nxt         = k1_r;
    d_nxt          = d_r;
    t_nxt          = t_r;
    w_nxt          = w_r;
    c0_nxt         = c0_r;
    c1_nxt         = c1_r;
    ch_nxt         = ch_r;
    bit_nxt        = bit_r;
    num_nxt        = num_r;
    div_nxt        = div_r;
    q_nxt          = q_r;
    res_color_nxt  = res_color_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_wr_addr    = idx_r[IW-1:0];
    ram_wr_key     = key_r;
    ram_wr_color   = color_r;
    ram_rd_addr    = idx_r[IW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt        = in_data.command;
          key_nxt        = in_data.key;
          color_nxt      = {in_data.alpha, in_data.blue, in_data.green, in_data.red};
          idx_nxt        = '0;
          res_color_nxt  = '0;
          res_status_nxt = STATUS_OK;
          if (in_data.command == CMD_LOOKUP && count_r == '0) begin
            res_status_nxt = STATUS_EMPTY;
            state_nxt      = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (idx_r == count_r) begin
          // sample or key above every stored key
          if (cmd_r == CMD_LOOKUP) begin
            ram_rd_addr = cnt_m1[IW-1:0];
            state_nxt   = S_EDGE;
          end else if (full) begin
            res_status_nxt = STATUS_FULL;
            state_nxt      = S_FIN;
          end else begin
            j_nxt     = count_r;
            state_nxt = S_SHIFT;
          end
        end else begin
          ram_rd_addr = idx_r[IW-1:0];
          state_nxt   = S_CMP;
        end
      end

      S_CMP: begin
        if (rd_key < key_r) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN;
        end else begin
          k1_nxt = rd_key;
          if (cmd_r == CMD_INSERT) begin
            if (rd_key == key_r) begin
              // replace colour of an existing point
              ram_we       = 1'b1;
              ram_wr_addr  = idx_r[IW-1:0];
              ram_wr_key   = key_r;
              ram_wr_color = color_r;
              state_nxt    = S_FIN;
            end else if (full) begin
              res_status_nxt = STATUS_FULL;
              state_nxt      = S_FIN;
            end else begin
              j_nxt     = count_r;
              state_nxt = S_SHIFT;
            end
          end else if (idx_r == '0) begin
            ram_rd_addr = idx_r[IW-1:0];
            state_nxt   = S_EDGE;
          end else begin
            ram_rd_addr = idx_r[IW-1:0];
            state_nxt   = S_GETHI;
          end
        end
      end

      S_SHIFT: begin
        if (j_r == idx_r) begin
          ram_we       = 1'b1;
          ram_wr_addr  = idx_r[IW-1:0];
          ram_wr_key   = key_r;
          ram_wr_color = color_r;
          count_nxt    = count_r + 1'b1;
          state_nxt    = S_FIN;
        end else begin
          ram_rd_addr = j_m1[IW-1:0];
          state_nxt   = S_SHWR;
        end
      end

      S_SHWR: begin
        ram_we       = 1'b1;
        ram_wr_addr  = j_r[IW-1:0];
        ram_wr_key   = rd_key;
        ram_wr_color = rd_color;
        j_nxt        = j_m1;
        state_nxt    = S_SHIFT;
      end

      S_EDGE: begin
        res_color_nxt = rd_color;
        state_nxt     = S_FIN;
      end

      S_GETHI: begin
        c1_nxt      = rd_color;
        ram_rd_addr = idx_m1[IW-1:0];
        state_nxt   = S_GETLO;
      end

      S_GETLO: begin
        c0_nxt    = rd_color;
        d_nxt     = k1_r - rd_key;
        t_nxt     = key_r - rd_key;
        w_nxt     = k1_r - key_r;
        ch_nxt    = '0;
        state_nxt = S_MUL0;
      end

      S_MUL0: begin
        num_nxt   = prod;
        state_nxt = S_MUL1;
      end

      S_MUL1: begin
        num_nxt   = num_r + prod;
        div_nxt   = {d_r, {(CH_W-1){1'b0}}};
        bit_nxt   = BIT_W'(CH_W - 1);
        q_nxt     = '0;
        state_nxt = S_DIV;
      end

      S_DIV: begin
        // one restoring step per cycle, quotient bit by bit from the top
        if (div_ge) begin
          num_nxt = num_r - {1'b0, div_r};
        end
        div_nxt = div_r >> 1;
        q_nxt   = {q_r[CH_W-2:0], div_ge};
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          res_color_nxt[CH_W*ch_r +: CH_W] = {q_r[CH_W-2:0], div_ge};
          if (ch_r == CHS_W'(NUM_CH - 1)) begin
            state_nxt = S_FIN;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_MUL0;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_red   = res_color_r[0*CH_W +: CH_W];
          out_data_nxt.out_green = res_color_r[1*CH_W +: CH_W];
          out_data_nxt.out_blue  = res_color_r[2*CH_W +: CH_W];
          out_data_nxt.out_alpha = res_color_r[3*CH_W +: CH_W];
          out_data_nxt.status    = res_status_r;
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    color_r      <= color_nxt;
    idx_r        <= idx_nxt;
    j_r          <= j_nxt;
    k1_r         <= k1_nxt;
    d_r          <= d_nxt;
    t_r          <= t_nxt;
    w_r          <= w_nxt;
    c0_r         <= c0_nxt;
    c1_r         <= c1_nxt;
    ch_r         <= ch_nxt;
    bit_r        <= bit_nxt;
    num_r        <= num_nxt;
    div_r        <= div_nxt;
    q_r          <= q_nxt;
    res_color_r  <= res_color_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  // table never holds more points than it has room for
  `PLC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(POINTS))
  // the point count only ever grows by one, at the end of an insert
  `PLC_ASSERT_NOW(a_count_step, $past(rst_n) && (count_r != $past(count_r)),
                  (count_r == $past(count_r) + 1'b1) && (state_r == S_FIN))
  // divider remainder stays below twice the shifted divisor
  `PLC_ASSERT_NOW(a_div_range, state_r == S_DIV, num_r < {div_r, 1'b0})
  // a new result is loaded only when the output register is free
  `PLC_ASSERT_NEXT(a_out_load, (state_r == S_FIN) && !out_free,
                   out_valid_r && $stable(out_data_r))

endmodule
